// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hrbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrbf_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int TOTAL_BITS = 32;
   localparam int KEY_POS_BITS = 4;

   localparam logic [KEY_POS_BITS-1:0] KEY_LEN = 4'd14;
   localparam logic [KEY_POS_BITS-1:0] KEY_POS_MAX = 4'd15;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_data_type;

   typedef struct packed {
      logic                  headers_found;
      logic                  complete;
      logic [TOTAL_BITS-1:0] total_length;
   } rsp_data_type;

   typedef enum logic [3:0] {
      PHASE_KEY   = 4'b0001,
      PHASE_SPACE = 4'b0010,
      PHASE_DIGIT = 4'b0100,
      PHASE_SKIP  = 4'b1000
   } line_phase_type;

   typedef enum logic [3:0] {
      TERM_NONE   = 4'b0001,
      TERM_CR     = 4'b0010,
      TERM_CRLF   = 4'b0100,
      TERM_CRLFCR = 4'b1000
   } term_state_type;

   // Lower-case header key, one character per position.
   function automatic logic [7:0] key_char(input logic [KEY_POS_BITS-1:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6f; // o
         4'd2:    ch = 8'h6e; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6e; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2d; // -
         4'd8:    ch = 8'h6c; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6e; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c | CASE_BIT;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/http_request_boundary_finder_unit.sv =====
// HTTP request boundary finder.
// req channel: one byte of a receive buffer per transfer, last_byte marks the
// final byte. The block finds the first CR LF CR LF, tracks the last
// Content-Length header before it and, on the marked byte, emits one result on
// the rsp channel: headers_found, complete (buffer holds headers plus body)
// and total_length (header length plus body length, saturated, zero when no
// header end was seen). Bytes that are not marked produce no result.
// Rate: one byte per cycle while req_stall is low, set by the single per-byte
// update of the parser state registers. The result of the marked byte passes
// the input register, the snapshot register taken with the parser update, and
// the output register with the final add and compare.
// Reset (synchronous) empties the pipeline and clears all parser state; the
// state also clears by itself after each marked byte.
// When rsp_stall is high the result holds in the output register; one more
// result can wait behind it, and non-marked bytes keep flowing until a second
// marked byte needs that slot, then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module http_request_boundary_finder_unit
   import hrbf_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_data_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_data_type      rsp_data
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_data_type s1_data_ff;

   // parser state
   term_state_type                term_ff, term_in;
   logic                          done_ff, done_in;
   logic [LENGTH_BITS-1:0]        bytes_ff, bytes_in;
   logic [LENGTH_BITS-1:0]        hlen_ff, hlen_in;
   line_phase_type                phase_ff, phase_in;
   logic [KEY_POS_BITS-1:0]       kpos_ff, kpos_in;
   logic                          kmis_ff, kmis_in;
   logic [LENGTH_BITS-1:0]        blen_ff, blen_in;

   // snapshot taken on the marked byte
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_done_ff;
   logic [LENGTH_BITS-1:0] s2_bytes_ff, s2_hlen_ff, s2_blen_ff;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic out_ready, s2_ready, s1_consume, req_take;
   logic [7:0] c;
   logic is_digit;
   logic [LENGTH_BITS+3:0] blen_scaled;
   logic [LENGTH_BITS:0] sum;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_consume = s1_valid_ff && (!s1_data_ff.last_byte || s2_ready);
   assign req_stall  = s1_valid_ff && !s1_consume;
   assign req_take   = req_valid && !req_stall;

   assign c        = s1_data_ff.data_byte;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign blen_scaled = ({4'b0, blen_ff} << 3) + ({4'b0, blen_ff} << 1)
                      + {{LENGTH_BITS{1'b0}}, c[3:0]};

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (s1_consume ? 1'b0 : s1_valid_ff);
   end

   // Per-byte parser update.
   always_comb begin
      term_in  = term_ff;
      done_in  = done_ff;
      bytes_in = (bytes_ff != LEN_MAX) ? bytes_ff + 1'b1 : bytes_ff;
      hlen_in  = hlen_ff;
      phase_in = phase_ff;
      kpos_in  = kpos_ff;
      kmis_in  = kmis_ff;
      blen_in  = blen_ff;

      if (!done_ff) begin
         // line parser
         if (c == CHAR_LF) begin
            phase_in = PHASE_KEY;
            kpos_in  = '0;
            kmis_in  = 1'b0;
         end else begin
            case (phase_ff)
               PHASE_KEY: begin
                  if (c == CHAR_COLON) begin
                     if (!kmis_ff && kpos_ff == KEY_LEN) begin
                        blen_in  = '0;
                        phase_in = PHASE_SPACE;
                     end else begin
                        phase_in = PHASE_SKIP;
                     end
                  end else begin
                     if (kpos_ff >= KEY_LEN || lower_ascii(c) != key_char(kpos_ff)) begin
                        kmis_in = 1'b1;
                     end
                     if (kpos_ff != KEY_POS_MAX) begin
                        kpos_in = kpos_ff + 1'b1;
                     end
                  end
               end
               PHASE_SPACE, PHASE_DIGIT: begin
                  if (is_digit) begin
                     blen_in = (blen_scaled[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                             ? LEN_MAX : blen_scaled[LENGTH_BITS-1:0];
                     phase_in = PHASE_DIGIT;
                  end else if (!(phase_ff == PHASE_SPACE && c == CHAR_SPACE)) begin
                     phase_in = PHASE_SKIP;
                  end
               end
               default: begin
               end
            endcase
         end

         // terminator match
         case (term_ff)
            TERM_NONE: term_in = (c == CHAR_CR) ? TERM_CR : TERM_NONE;
            TERM_CR: begin
               if (c == CHAR_LF)      term_in = TERM_CRLF;
               else if (c == CHAR_CR) term_in = TERM_CR;
               else                   term_in = TERM_NONE;
            end
            TERM_CRLF: term_in = (c == CHAR_CR) ? TERM_CRLFCR : TERM_NONE;
            TERM_CRLFCR: begin
               if (c == CHAR_LF) begin
                  done_in = 1'b1;
                  hlen_in = bytes_in;
                  term_in = TERM_NONE;
               end else begin
                  term_in = (c == CHAR_CR) ? TERM_CR : TERM_NONE;
               end
            end
            default: term_in = TERM_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         term_ff     <= TERM_NONE;
         done_ff     <= 1'b0;
         bytes_ff    <= '0;
         hlen_ff     <= '0;
         phase_ff    <= PHASE_KEY;
         kpos_ff     <= '0;
         kmis_ff     <= 1'b0;
         blen_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_consume) begin
            if (s1_data_ff.last_byte) begin
               // clear for the next buffer
               term_ff  <= TERM_NONE;
               done_ff  <= 1'b0;
               bytes_ff <= '0;
               hlen_ff  <= '0;
               phase_ff <= PHASE_KEY;
               kpos_ff  <= '0;
               kmis_ff  <= 1'b0;
               blen_ff  <= '0;
            end else begin
               term_ff  <= term_in;
               done_ff  <= done_in;
               bytes_ff <= bytes_in;
               hlen_ff  <= hlen_in;
               phase_ff <= phase_in;
               kpos_ff  <= kpos_in;
               kmis_ff  <= kmis_in;
               blen_ff  <= blen_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_consume && s1_data_ff.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_consume && s1_data_ff.last_byte) begin
         s2_done_ff  <= done_in;
         s2_bytes_ff <= bytes_in;
         s2_hlen_ff  <= hlen_in;
         s2_blen_ff  <= blen_in;
      end
   end

   // Final add and compare.
   assign sum = {1'b0, s2_hlen_ff} + {1'b0, s2_blen_ff};

   always_comb begin
      rsp_data_in.headers_found = s2_done_ff;
      rsp_data_in.complete      = 1'b0;
      rsp_data_in.total_length  = '0;
      if (s2_done_ff) begin
         if (sum[LENGTH_BITS]) begin
            rsp_data_in.total_length = TOTAL_BITS'(LEN_MAX);
         end else begin
            rsp_data_in.total_length = TOTAL_BITS'(sum[LENGTH_BITS-1:0]);
            rsp_data_in.complete     = (s2_bytes_ff >= sum[LENGTH_BITS-1:0]);
         end
      end
      rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hrbf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hrbf_checker
   import hrbf_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_data_type req_data,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_data_type rsp_data
);

   // hold a stalled result
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result changed")

   // hold a stalled request
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_data), "stalled request changed")

   `ASSERT_SAME(a_complete_needs_headers, clock, reset, rsp_valid && rsp_data.complete,
      rsp_data.headers_found, "complete without header end")

   `ASSERT_SAME(a_total_zero_without_headers, clock, reset,
      rsp_valid && !rsp_data.headers_found,
      rsp_data.total_length == '0, "nonzero total without header end")

   // with the output slot empty the pipeline always drains
   `ASSERT_SAME(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall,
      "input stalled while output empty")

endmodule

bind http_request_boundary_finder_unit hrbf_checker u_hrbf_checker (.*);

`default_nettype wire
